[hdl/m4te_pkg.sv]
`timescale 1ns / 1ps
package m4te_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int IO_BITS = 32;
    localparam int DEPTH = 16;
    localparam int ADDR_BITS = 4;
    localparam int ACC_BITS = 2 * WORD_BITS + 3;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [ACC_BITS-1:0] acc_t;

    typedef enum logic [2:0] {
        OP_WR_CUR = 3'd0,
        OP_WR_OPD = 3'd1,
        OP_MUL    = 3'd2,
        OP_XFORM  = 3'd3,
        OP_CMP    = 3'd4,
        OP_RD     = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        PH_CLR,
        PH_IDLE,
        PH_RUN,
        PH_COPY,
        PH_OUT
    } state_t;

    localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Sign-extend or saturate a 32-bit input word to the internal word.
    function automatic word_t fit_in(input logic signed [IO_BITS-1:0] v, output logic ovf);
        logic signed [IO_BITS+WORD_BITS-1:0] e;
        begin
            e = (IO_BITS+WORD_BITS)'(v);
            ovf = 1'b0;
            if (e > (IO_BITS+WORD_BITS)'(WMAX))
            begin
                ovf = 1'b1;
                fit_in = WMAX;
            end
            else if (e < (IO_BITS+WORD_BITS)'(WMIN))
            begin
                ovf = 1'b1;
                fit_in = WMIN;
            end
            else
            begin
                fit_in = word_t'(e);
            end
        end
    endfunction

    // Truncate an accumulator by the fraction bits and saturate.
    function automatic word_t fit_acc(input acc_t a, output logic ovf);
        acc_t s;
        begin
            s = a >>> FRAC_BITS;
            ovf = 1'b0;
            if (s > ACC_BITS'(WMAX))
            begin
                ovf = 1'b1;
                fit_acc = WMAX;
            end
            else if (s < ACC_BITS'(WMIN))
            begin
                ovf = 1'b1;
                fit_acc = WMIN;
            end
            else
            begin
                fit_acc = word_t'(s);
            end
        end
    endfunction
endpackage

[hdl/m4te_ram.sv]
`timescale 1ns / 1ps
module m4te_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/m4te_mac.sv]
`timescale 1ns / 1ps
module m4te_mac (
    input  logic             clk,
    input  logic             clr,
    input  logic             en,
    input  m4te_pkg::word_t  a,
    input  m4te_pkg::word_t  b,
    output m4te_pkg::acc_t   acc
);
    import m4te_pkg::*;

    logic signed [2*WORD_BITS-1:0] prod;
    acc_t acc_reg;

    assign prod = a * b;
    assign acc = acc_reg;

    // One multiply-accumulate per enabled cycle.
    always_ff @(posedge clk)
    begin
        if (clr)
        begin
            acc_reg <= '0;
        end
        else if (en)
        begin
            acc_reg <= acc_reg + ACC_BITS'(prod);
        end
    end
endmodule

[hdl/mat4_transform_engine.sv]
`timescale 1ns / 1ps
// 4x4 fixed-point matrix engine. It has one multiply-accumulate unit, which reads one current element
// and (for a multiply) one operand element a cycle from memories with one read and one write port;
// matrix products go to a scratch memory and are then copied back into the current matrix.
// After reset a clearing pass zeroes both matrices; no beat is taken.
module mat4_transform_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [3:0]  index,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_z,
    input  logic signed [31:0] in_w,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic signed [31:0] out_w,
    output logic        equal,
    output logic        overflow
);
    import m4te_pkg::*;

    state_t ph_reg, ph_next;
    logic [2:0] op_reg;
    logic [ADDR_BITS-1:0] idx_reg;
    word_t vec_reg [4];
    logic [7:0] cnt_reg, cnt_next;
    logic ovf_reg, eq_reg;
    word_t res_reg [4];
    logic out_valid_reg;

    // Memory ports.
    logic cur_we, opd_we, tmp_we;
    logic [ADDR_BITS-1:0] cur_wa, opd_wa, tmp_wa, cur_ra, opd_ra, tmp_ra;
    word_t cur_wd, opd_wd, tmp_wd, cur_rd, opd_rd, tmp_rd;

    m4te_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_wa), .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
    m4te_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_opd (
        .clk(clk), .we(opd_we), .waddr(opd_wa), .wdata(opd_wd), .raddr(opd_ra), .rdata(opd_rd));
    m4te_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_tmp (
        .clk(clk), .we(tmp_we), .waddr(tmp_wa), .wdata(tmp_wd), .raddr(tmp_ra), .rdata(tmp_rd));

    // Sequencing: step k = cnt_reg[1:0]; a read is issued at count t and used from the memory's read register.
    // Multiply: t = 0..63 reads, element e = t[5:2], i = e[3:2], j = e[1:0].
    // Transform: t = 0..15, row i = t[3:2].
    logic [1:0] k_iss, i_iss, j_iss;
    logic issue, use_q, last_k_q;
    logic [1:0] k_q;
    logic [ADDR_BITS-1:0] e_q;
    logic mac_clr, mac_en;
    word_t mac_a, mac_b;
    acc_t acc;
    acc_t acc_sum;
    logic fit_ovf;
    word_t fit_val;
    logic [ADDR_BITS-1:0] e_iss;
    logic [7:0] run_len;

    assign run_len = (op_reg == OP_MUL) ? 8'd64 : 8'd16;
    assign k_iss = cnt_reg[1:0];
    assign e_iss = (op_reg == OP_MUL) ? cnt_reg[5:2] : {cnt_reg[3:2], 2'b00};
    assign i_iss = e_iss[3:2];
    assign j_iss = e_iss[1:0];
    assign issue = (ph_reg == PH_RUN) && (cnt_reg < run_len);

    m4te_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b), .acc(acc));

    // Delayed issue tags line up with the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_q <= 1'b0;
        end
        else
        begin
            use_q <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        k_q <= k_iss;
        e_q <= e_iss;
        last_k_q <= (k_iss == 2'd3);
    end

    // The accumulator restarts after the fourth product of each dot product.
    assign mac_a = cur_rd;
    assign mac_b = (op_reg == OP_MUL) ? opd_rd : vec_reg[k_q];
    assign mac_en = use_q && (op_reg == OP_MUL || op_reg == OP_XFORM);
    assign mac_clr = (ph_reg == PH_IDLE) || (use_q && last_k_q) ||
                     (ph_reg == PH_RUN && cnt_reg == 8'd0);
    assign acc_sum = acc + ACC_BITS'(mac_a * mac_b);

    always_comb
    begin
        fit_val = fit_acc(acc_sum, fit_ovf);
    end

    // Memory port control.
    always_comb
    begin
        cur_we = 1'b0; cur_wa = idx_reg; cur_wd = vec_reg[0];
        opd_we = 1'b0; opd_wa = idx_reg; opd_wd = vec_reg[0];
        tmp_we = 1'b0; tmp_wa = e_q; tmp_wd = fit_val;
        cur_ra = {i_iss, k_iss};
        opd_ra = (op_reg == OP_MUL) ? {k_iss, j_iss} : cnt_reg[3:0];
        tmp_ra = cnt_reg[3:0];
        case (ph_reg)
            PH_CLR:
            begin
                cur_we = 1'b1; cur_wa = cnt_reg[3:0]; cur_wd = '0;
                opd_we = 1'b1; opd_wa = cnt_reg[3:0]; opd_wd = '0;
            end
            PH_RUN:
            begin
                // Element writes are done in the run state, which they then leave for the output state.
                if (op_reg == OP_WR_CUR)
                begin
                    cur_we = 1'b1;
                end
                if (op_reg == OP_WR_OPD)
                begin
                    opd_we = 1'b1;
                end
                if (op_reg == OP_CMP || op_reg == OP_RD)
                begin
                    cur_ra = (op_reg == OP_RD) ? idx_reg : cnt_reg[3:0];
                end
                if (op_reg == OP_MUL && use_q && last_k_q)
                begin
                    tmp_we = 1'b1;
                end
            end
            PH_COPY:
            begin
                if (cnt_reg != 8'd0)
                begin
                    cur_we = 1'b1;
                    cur_wa = 4'(cnt_reg - 8'd1);
                    cur_wd = tmp_rd;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state machine.
    logic cmd_ok;
    assign cmd_ok = in_valid && !in_stall;
    assign in_stall = (ph_reg != PH_IDLE);

    always_comb
    begin
        ph_next = ph_reg;
        cnt_next = cnt_reg;
        case (ph_reg)
            PH_CLR:
            begin
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'(DEPTH - 1))
                begin
                    ph_next = PH_IDLE;
                    cnt_next = '0;
                end
            end
            PH_IDLE:
            begin
                cnt_next = '0;
                if (cmd_ok)
                begin
                    ph_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                cnt_next = cnt_reg + 8'd1;
                if (op_reg == OP_CMP)
                begin
                    if (cnt_reg == 8'd16)
                    begin
                        ph_next = PH_OUT;
                    end
                end
                else if (op_reg == OP_MUL || op_reg == OP_XFORM)
                begin
                    if (cnt_reg == run_len)
                    begin
                        ph_next = (op_reg == OP_MUL) ? PH_COPY : PH_OUT;
                        cnt_next = '0;
                    end
                end
                else if (op_reg == OP_RD)
                begin
                    if (cnt_reg == 8'd1)
                    begin
                        ph_next = PH_OUT;
                    end
                end
                else
                begin
                    ph_next = PH_OUT;
                end
            end
            PH_COPY:
            begin
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == 8'd16)
                begin
                    ph_next = PH_OUT;
                end
            end
            PH_OUT:
            begin
                if (out_valid_reg && !out_stall)
                begin
                    ph_next = PH_IDLE;
                end
            end
            default:
            begin
                ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_CLR;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ph_reg <= ph_next;
            cnt_reg <= cnt_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (ph_reg != PH_OUT && ph_next == PH_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Command capture, results and flags.
    logic v_ovf [4];
    word_t v_fit [4];
    always_comb
    begin
        v_fit[0] = fit_in(in_x, v_ovf[0]);
        v_fit[1] = fit_in(in_y, v_ovf[1]);
        v_fit[2] = fit_in(in_z, v_ovf[2]);
        v_fit[3] = fit_in(in_w, v_ovf[3]);
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ok)
        begin
            op_reg <= opcode;
            idx_reg <= index;
            for (int n = 0; n < 4; n++)
            begin
                vec_reg[n] <= v_fit[n];
                res_reg[n] <= '0;
            end
            eq_reg <= (opcode == OP_CMP);
            case (opcode)
                OP_XFORM: ovf_reg <= v_ovf[0] | v_ovf[1] | v_ovf[2] | v_ovf[3];
                OP_WR_CUR, OP_WR_OPD: ovf_reg <= v_ovf[0];
                default: ovf_reg <= 1'b0;
            endcase
        end
        else if (ph_reg == PH_RUN)
        begin
            if (use_q && (op_reg == OP_MUL || op_reg == OP_XFORM) && last_k_q)
            begin
                ovf_reg <= ovf_reg | fit_ovf;
                if (op_reg == OP_XFORM)
                begin
                    res_reg[e_q[3:2]] <= fit_val;
                end
            end
            if (use_q && op_reg == OP_CMP && cur_rd != opd_rd)
            begin
                eq_reg <= 1'b0;
            end
            if (use_q && op_reg == OP_RD)
            begin
                res_reg[0] <= cur_rd;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x = IO_BITS'(res_reg[0]);
    assign out_y = IO_BITS'(res_reg[1]);
    assign out_z = IO_BITS'(res_reg[2]);
    assign out_w = IO_BITS'(res_reg[3]);
    assign equal = eq_reg;
    assign overflow = ovf_reg;
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import m4te_pkg::*;

    // Opcodes that the block leaves unused.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam int RAND_ITEMS = 700;
    localparam int QUIET_FROM = 600;
    localparam int WATCH_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        bit          typed;
        logic [31:0] rx;
        bit          req;
        bit          rov;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        bit          eq;
        bit          ov;
    } result_t;

    localparam int NDIR = 22;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] PMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NMIN = 32'h8000_0000;

    stim_row_t dir_tab [NDIR] = '{
        '{OP_RD,     4'd0,  0,    0, 0, 0, 1, 0,    0, 0},
        '{OP_CMP,    4'd0,  0,    0, 0, 0, 1, 0,    1, 0},
        '{OP_WR_CUR, 4'd0,  PMAX, 0, 0, 0, 1, 0,    0, 0},
        '{OP_WR_CUR, 4'd15, NMIN, 0, 0, 0, 1, 0,    0, 0},
        '{OP_RD,     4'd0,  0,    0, 0, 0, 1, PMAX, 0, 0},
        '{OP_RD,     4'd15, 0,    0, 0, 0, 1, NMIN, 0, 0},
        '{OP_SPARE_A, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1, 0, 0, 0},
        '{OP_SPARE_B, 4'd7, PMAX, NMIN, PMAX, NMIN, 1, 0, 0, 0},
        '{OP_CMP,    4'd0,  0,    0, 0, 0, 1, 0,    0, 0},
        '{OP_XFORM,  4'd0,  PMAX, 0, 0, NMIN, 0, 0, 0, 0},
        '{OP_WR_CUR, 4'd0,  ONE,  0, 0, 0, 0, 0,    0, 0},
        '{OP_WR_CUR, 4'd5,  ONE,  0, 0, 0, 0, 0,    0, 0},
        '{OP_WR_CUR, 4'd10, ONE,  0, 0, 0, 0, 0,    0, 0},
        '{OP_WR_CUR, 4'd15, ONE,  0, 0, 0, 0, 0,    0, 0},
        '{OP_XFORM,  4'd0,  32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_8000,
          32'hFFFF_0001, 0, 0, 0, 0},
        '{OP_WR_OPD, 4'd0,  32'h0002_0000, 0, 0, 0, 0, 0, 0, 0},
        '{OP_WR_OPD, 4'd5,  32'hFFFF_8000, 0, 0, 0, 0, 0, 0, 0},
        '{OP_MUL,    4'd0,  0,    0, 0, 0, 0, 0,    0, 0},
        '{OP_RD,     4'd0,  0,    0, 0, 0, 0, 0,    0, 0},
        '{OP_RD,     4'd5,  0,    0, 0, 0, 0, 0,    0, 0},
        '{OP_XFORM,  4'd0,  PMAX, PMAX, PMAX, PMAX, 0, 0, 0, 0},
        '{OP_CMP,    4'd0,  0,    0, 0, 0, 0, 0,    0, 0}
    };

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] opcode;
    logic [3:0] index;
    logic signed [31:0] in_x, in_y, in_z, in_w;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic equal;
    logic overflow;

    mat4_transform_engine u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .index(index),
        .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_w(in_w),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
        .equal(equal), .overflow(overflow)
    );

    // Shadow copies of the two matrices.
    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opd_mat [16];
    result_t pending_q [$];

    int errors = 0;
    int items_in = 0;
    int beats_out = 0;
    int n_mul = 0, n_xform = 0, n_eq = 0, n_ovf = 0;
    bit quiet = 0;
    bit stim_done = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Truncated and saturated dot product of two packed four-word vectors.
    function automatic logic signed [31:0] sat_dot(input logic [127:0] a,
                                                   input logic [127:0] b,
                                                   inout bit ov);
        logic signed [66:0] acc;
        logic signed [63:0] p;
        logic signed [66:0] s;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            p = $signed(a[k*32 +: 32]) * $signed(b[k*32 +: 32]);
            acc = acc + {{3{p[63]}}, p};
        end
        s = acc >>> FRAC_BITS;
        if (s > 67'sd2147483647)
        begin
            ov = 1;
            return PMAX;
        end
        if (s < -67'sd2147483648)
        begin
            ov = 1;
            return NMIN;
        end
        return s[31:0];
    endfunction

    // Apply one beat to the shadow matrices and return the result it produces.
    function automatic result_t predict_beat(input logic [2:0] op, input logic [3:0] idx,
                                             input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z, input logic [31:0] w);
        result_t r;
        logic signed [31:0] prod [16];
        logic [127:0] row, col, vec;
        bit ov;
        r = '0;
        ov = 0;
        case (op)
            OP_WR_CUR: cur_mat[idx] = x;
            OP_WR_OPD: opd_mat[idx] = x;
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                    for (int j = 0; j < 4; j++)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            row[k*32 +: 32] = cur_mat[i*4 + k];
                            col[k*32 +: 32] = opd_mat[k*4 + j];
                        end
                        prod[i*4 + j] = sat_dot(row, col, ov);
                    end
                for (int i = 0; i < 16; i++)
                    cur_mat[i] = prod[i];
            end
            OP_XFORM:
            begin
                vec = {w, z, y, x};
                for (int i = 0; i < 4; i++)
                begin
                    for (int k = 0; k < 4; k++)
                        row[k*32 +: 32] = cur_mat[i*4 + k];
                    case (i)
                        0: r.x = sat_dot(row, vec, ov);
                        1: r.y = sat_dot(row, vec, ov);
                        2: r.z = sat_dot(row, vec, ov);
                        default: r.w = sat_dot(row, vec, ov);
                    endcase
                end
            end
            OP_CMP:
            begin
                r.eq = 1;
                for (int i = 0; i < 16; i++)
                    if (cur_mat[i] !== opd_mat[i])
                        r.eq = 0;
            end
            OP_RD: r.x = cur_mat[idx];
            default: ;
        endcase
        r.ov = ov;
        return r;
    endfunction

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(input logic [2:0] op, input logic [3:0] idx,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w,
                             input bit typed, input result_t typed_res);
        result_t r;
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        index <= idx;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        in_w <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = predict_beat(op, idx, x, y, z, w);
        pending_q.push_back(typed ? typed_res : r);
        items_in++;
        if (op == OP_MUL) n_mul++;
        if (op == OP_XFORM) n_xform++;
        if (r.eq) n_eq++;
        if (r.ov) n_ovf++;
        // Random gap on the sending side.
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return PMAX;
            1: return NMIN;
            2, 3: return $urandom();
            4: return $urandom_range(0, 1) ? ONE : -ONE;
            default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0001_FFFF;
        endcase
    endfunction

    // Stimulus: reset, directed table, then random beats.
    initial
    begin
        stim_row_t row;
        result_t tr;
        logic [2:0] op;
        int pick;
        logic [31:0] v;
        bit drained;
        drained = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = '0;
        index = '0;
        in_x = '0;
        in_y = '0;
        in_z = '0;
        in_w = '0;
        for (int i = 0; i < 16; i++)
        begin
            cur_mat[i] = '0;
            opd_mat[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NDIR; i++)
        begin
            row = dir_tab[i];
            tr = '{row.rx, 32'd0, 32'd0, 32'd0, row.req, row.rov};
            send_beat(row.op, row.idx, row.x, row.y, row.z, row.w, row.typed, tr);
        end

        while (items_in < NDIR + RAND_ITEMS)
        begin
            if (items_in - NDIR >= QUIET_FROM)
                quiet = 1;
            // Let the pipeline drain completely once, mid-run.
            if (!drained && items_in - NDIR >= 300)
            begin
                drained = 1;
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_q.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                // Mirror both matrices, then compare: equal should come back set.
                for (int i = 0; i < 16; i++)
                begin
                    v = rand_word();
                    send_beat(OP_WR_CUR, 4'(i), v, $urandom(), $urandom(), $urandom(), 0, '0);
                    send_beat(OP_WR_OPD, 4'(i), v, $urandom(), $urandom(), $urandom(), 0, '0);
                end
                send_beat(OP_CMP, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                          $urandom(), 0, '0);
            end
            else
            begin
                if (pick < 45) op = $urandom_range(0, 1) ? OP_WR_CUR : OP_WR_OPD;
                else if (pick < 68) op = OP_XFORM;
                else if (pick < 78) op = OP_MUL;
                else if (pick < 85) op = OP_CMP;
                else if (pick < 96) op = OP_RD;
                else op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                send_beat(op, 4'($urandom_range(0, 15)), rand_word(), rand_word(),
                          rand_word(), rand_word(), 0, '0);
            end
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Result side stall: random bursts plus one long hold-off.
    initial
    begin
        int n;
        bit held;
        held = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && items_in >= 150)
            begin
                held = 1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 11);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    // Check each result beat against the oldest expectation.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual x=%h",
                         $time, out_x);
            end
            else
            begin
                e = pending_q.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_w !== e.w)
                begin
                    errors++;
                    $display("%0t: vector mismatch expected %h %h %h %h actual %h %h %h %h",
                             $time, e.x, e.y, e.z, e.w, out_x, out_y, out_z, out_w);
                end
                if (equal !== e.eq)
                begin
                    errors++;
                    $display("%0t: equal mismatch expected %0b actual %0b",
                             $time, e.eq, equal);
                end
                if (overflow !== e.ov)
                begin
                    errors++;
                    $display("%0t: overflow mismatch expected %0b actual %0b",
                             $time, e.ov, overflow);
                end
            end
        end
    end

    // Watchdog on cycles with no beat moving on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // End of run: drain, allow stray beats to show, then report.
    initial
    begin
        wait (stim_done);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (pending_q.size() != 0)
            errors++;
        $display("Covered %0d beats in, %0d results out: %0d multiplies, %0d transforms,",
                 items_in, beats_out, n_mul, n_xform);
        $display("%0d equal compares, %0d saturating beats, %0d errors.",
                 n_eq, n_ovf, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
